// ----- rtl/core/aonl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aonl_pkg
// Types, codes and sizes shared by the node pool controller and datapath.
// ----------------------------------------------------------------------------
package aonl_pkg;

  localparam int POOL_DEPTH = 512;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam int COORD_W  = 16;
  localparam int COST_W   = 20;
  localparam int PIDX_W   = 9;
  localparam int TGT_W    = 10;
  localparam int RIDX_W   = 9;
  localparam int COUNT_W  = 10;

  localparam logic [COST_W-1:0] COST_LIMIT = 20'd100000;

  typedef enum logic [2:0] {
    REQ_CLEAR        = 3'd0,
    REQ_APPEND       = 3'd1,
    REQ_BEST         = 3'd2,
    REQ_CLOSE        = 3'd3,
    REQ_COUNT_CLOSED = 3'd4,
    REQ_COUNT_OPEN   = 3'd5,
    REQ_LOOKUP       = 3'd6,
    REQ_READ         = 3'd7
  } req_type_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [COORD_W-1:0]  node_x;
    logic [COORD_W-1:0]  node_y;
    logic [COST_W-1:0]   node_cost;
    logic [PIDX_W-1:0]   parent_index;
    logic                parent_present;
    logic [TGT_W-1:0]    target_index;
  } in_beat_t;

  typedef struct packed {
    logic                ok;
    logic [RIDX_W-1:0]   result_index;
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [COST_W-1:0]   out_cost;
    logic [PIDX_W-1:0]   out_parent;
    logic                out_has_parent;
    logic [COUNT_W-1:0]  count;
  } out_beat_t;

  // one pool entry as held in the node RAM
  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COST_W-1:0]   cost;
    logic                parent_present;
    logic [PIDX_W-1:0]   parent_index;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_req;
    logic do_clear;
    logic do_append;
    logic do_close;
    logic issue_read;
    logic issue_scan;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    req_type_t req_type;
    logic      pool_full;
    logic      pool_empty;
    logic      close_ok;
    logic      read_ok;
    logic      scan_last;
    logic      out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/astar_open_list_node_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_open_list_node_table_core
// Append-only pool of best-first search nodes with open marks, one request
// at a time and one result beat per request.
// ----------------------------------------------------------------------------
// One request is in work at a time. Clear, append and close go from idle
// through start to finish, where the result beat is loaded; an in-range node
// read also passes drain. Best open, both counts and coordinate lookup scan
// the used entries and then drain (an empty pool goes from start straight to
// finish); every used entry is fetched through the single read port of the
// node and mark RAMs, one entry a cycle.
// A finished result waits in the output register while the next request is
// accepted; that request completes once the register has been taken. Clear
// only zeroes the fill count and reset also clears the valid flags, so there
// is no clearing pass and the block is ready as soon as reset is released.
module astar_open_list_node_table_core
  import aonl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  aonl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  aonl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/aonl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aonl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module aonl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/aonl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aonl_ctrl
// Request sequencer: takes one request, runs its write, its node read or its
// scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module aonl_ctrl
  import aonl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (status.req_type inside {REQ_CLEAR, REQ_APPEND, REQ_CLOSE}) begin
          state_nxt = ST_FINISH;
        end else if (status.req_type == REQ_READ) begin
          state_nxt = status.read_ok ? ST_DRAIN : ST_FINISH;
        end else begin
          state_nxt = status.pool_empty ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_START: begin
        cmd.do_clear   = (status.req_type == REQ_CLEAR);
        cmd.do_append  = (status.req_type == REQ_APPEND) && !status.pool_full;
        cmd.do_close   = (status.req_type == REQ_CLOSE) && status.close_ok;
        cmd.issue_read = (status.req_type == REQ_READ) && status.read_ok;
      end
      ST_SCAN: begin
        cmd.issue_scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/aonl_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aonl_dp
// Node pool datapath: node and open-mark RAMs, fill count, scan pointer,
// scan accumulators and the result register.
// ----------------------------------------------------------------------------
module aonl_dp
  import aonl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_beat_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  logic       out_ready,
  output logic       out_valid,
  output out_beat_t  out_data
);

  in_beat_t          req_r, req_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              rd_valid_r, rd_valid_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  acc_idx_r, acc_idx_nxt;
  node_t             acc_node_r, acc_node_nxt;
  logic [COST_W-1:0] best_cost_r, best_cost_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_r, out_nxt;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [NODE_W-1:0] rd_node_raw;
  node_t             rd_node;
  logic [0:0]        rd_mark;
  node_t             wr_node;
  logic              mark_we;
  logic [IDX_W-1:0]  mark_waddr;
  out_beat_t         res;

  // ---------------------------------------------------------------- storage
  assign rd_en   = cmd.issue_read || cmd.issue_scan;
  assign rd_addr = cmd.issue_read ? IDX_W'(req_r.target_index) : scan_idx_r;

  assign wr_node.x              = req_r.node_x;
  assign wr_node.y              = req_r.node_y;
  assign wr_node.cost           = req_r.node_cost;
  assign wr_node.parent_present = req_r.parent_present;
  assign wr_node.parent_index   = req_r.parent_index;

  // entries at or above the fill count are never read, so neither RAM needs clearing
  assign mark_we    = cmd.do_append || cmd.do_close;
  assign mark_waddr = cmd.do_append ? IDX_W'(used_r) : IDX_W'(req_r.target_index);

  aonl_ram #(
    .WIDTH (NODE_W),
    .DEPTH (POOL_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (cmd.do_append),
    .waddr (IDX_W'(used_r)),
    .wdata (wr_node),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_node_raw)
  );

  aonl_ram #(
    .WIDTH (1),
    .DEPTH (POOL_DEPTH)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (cmd.do_append),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_mark)
  );

  assign rd_node = node_t'(rd_node_raw);

  // ---------------------------------------------------------------- status
  assign status.req_type   = req_r.req_type;
  assign status.pool_full  = (used_r >= CNT_W'(POOL_DEPTH));
  assign status.pool_empty = (used_r == '0);
  assign status.close_ok   = (32'(req_r.target_index) < 32'(POOL_DEPTH));
  assign status.read_ok    = (32'(req_r.target_index) < 32'(used_r));
  assign status.scan_last  = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == used_r);
  assign status.out_free   = !out_valid_r || out_ready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    req_nxt       = req_r;
    used_nxt      = used_r;
    scan_idx_nxt  = scan_idx_r;
    rd_valid_nxt  = rd_en;
    rd_idx_nxt    = rd_addr;
    found_nxt     = found_r;
    acc_idx_nxt   = acc_idx_r;
    acc_node_nxt  = acc_node_r;
    best_cost_nxt = best_cost_r;
    cnt_nxt       = cnt_r;

    if (cmd.load_req) begin
      req_nxt       = in_data;
      scan_idx_nxt  = '0;
      found_nxt     = 1'b0;
      acc_idx_nxt   = '0;
      acc_node_nxt  = '0;
      best_cost_nxt = COST_LIMIT;
      cnt_nxt       = '0;
    end

    if (cmd.do_clear) begin
      used_nxt = '0;
    end
    if (cmd.do_append) begin
      used_nxt    = used_r + CNT_W'(1);
      found_nxt   = 1'b1;
      acc_idx_nxt = IDX_W'(used_r);
    end
    if (cmd.do_close) begin
      found_nxt = 1'b1;
    end
    if (cmd.issue_scan) begin
      scan_idx_nxt = scan_idx_r + IDX_W'(1);
    end

    // data read in the previous cycle
    if (rd_valid_r) begin
      case (req_r.req_type)
        REQ_BEST: begin
          if (rd_mark[0] && (rd_node.cost < best_cost_r)) begin
            best_cost_nxt = rd_node.cost;
            acc_idx_nxt   = rd_idx_r;
            acc_node_nxt  = rd_node;
            found_nxt     = 1'b1;
          end
        end
        REQ_COUNT_CLOSED: begin
          if (!rd_mark[0]) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        REQ_COUNT_OPEN: begin
          if (rd_mark[0]) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        REQ_LOOKUP: begin
          if ((rd_node.x == req_r.node_x) && (rd_node.y == req_r.node_y)) begin
            found_nxt = 1'b1;
          end
        end
        REQ_READ: begin
          found_nxt    = 1'b1;
          acc_node_nxt = rd_node;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    res = '0;
    case (req_r.req_type)
      REQ_APPEND: begin
        res.ok           = found_r;
        res.result_index = RIDX_W'(acc_idx_r);
      end
      REQ_BEST: begin
        res.ok           = found_r;
        res.result_index = RIDX_W'(acc_idx_r);
        res.out_x        = acc_node_r.x;
        res.out_y        = acc_node_r.y;
        res.out_cost     = acc_node_r.cost;
      end
      REQ_CLOSE, REQ_LOOKUP: begin
        res.ok = found_r;
      end
      REQ_COUNT_CLOSED, REQ_COUNT_OPEN: begin
        res.count = COUNT_W'(cnt_r);
      end
      REQ_READ: begin
        res.ok             = found_r;
        res.out_x          = acc_node_r.x;
        res.out_y          = acc_node_r.y;
        res.out_cost       = acc_node_r.cost;
        res.out_parent     = acc_node_r.parent_index;
        res.out_has_parent = acc_node_r.parent_present;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    out_nxt       = cmd.load_out ? res : out_r;
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    scan_idx_r  <= scan_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    found_r     <= found_nxt;
    acc_idx_r   <= acc_idx_nxt;
    acc_node_r  <= acc_node_nxt;
    best_cost_r <= best_cost_nxt;
    cnt_r       <= cnt_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/aonl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aonl_checker
// Port-level checks on the node pool core, bound to the top level.
// ----------------------------------------------------------------------------
module aonl_checker
  import aonl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // an offered request beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one request in work: never two accepts on consecutive edges
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // counts only come from count requests, which never report ok
  a_count_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.count != '0) |-> !out_data.ok)
    else $error("count beat with ok set");

  // parent flag and node index only come with a successful request
  a_fields_need_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.out_has_parent || (out_data.result_index != '0))
    |-> out_data.ok)
    else $error("node fields without ok");

endmodule

bind astar_open_list_node_table_core aonl_checker u_aonl_checker (.*);

// ----- sim/astar_open_list_node_table_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_open_list_node_table_core_tb
// Checks the search node pool against a cycle-free model of its requests.
// A directed opening covers empty-pool queries, cost limits, best-node ties,
// out-of-range closes and reads; random episodes then clear the pool and mix
// appends, best/close/count/lookup/read and raw noise, with one episode that
// fills the pool and overflows it. Both channels idle at random.
// ----------------------------------------------------------------------------
module astar_open_list_node_table_core_tb;
  import aonl_pkg::*;

  localparam int QUIET_TAIL   = 40;
  localparam int HOLD_AT      = 10;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = POOL_DEPTH + 8;
  localparam int TIMEOUT_NS   = 40_000_000;
  localparam int SMALL_TARGET = 240;
  localparam int FULL_AT      = 100;

  typedef struct {
    in_beat_t beat;
    bit       wait_idle;
  } req_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  astar_open_list_node_table_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // pool image used for prediction
  bit [COORD_W-1:0] node_x_mem [POOL_DEPTH];
  bit [COORD_W-1:0] node_y_mem [POOL_DEPTH];
  bit [COST_W-1:0]  node_cost_mem [POOL_DEPTH];
  bit [PIDX_W-1:0]  node_par_mem [POOL_DEPTH];
  bit               node_has_par [POOL_DEPTH];
  bit               open_mark [POOL_DEPTH];
  int               fill_cnt = 0;

  // shadow of the fill level and coordinates, used only to shape stimulus
  logic [COORD_W-1:0] gen_x [POOL_DEPTH];
  logic [COORD_W-1:0] gen_y [POOL_DEPTH];
  int                 gen_fill = 0;

  req_item_t req_queue [$];
  out_beat_t pending_results [$];
  int        n_in = 0;
  int        n_out = 0;
  int        err_cnt = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  function automatic out_beat_t pool_predict(in_beat_t rq);
    out_beat_t        r;
    logic [COST_W-1:0] best_cost;
    int               best;
    bit               found;
    int               n;
    r = '0;
    case (rq.req_type)
      REQ_CLEAR: begin
        fill_cnt = 0;
        for (int i = 0; i < POOL_DEPTH; i++) open_mark[i] = 1'b0;
      end
      REQ_APPEND: begin
        if (fill_cnt < POOL_DEPTH) begin
          node_x_mem[fill_cnt]    = rq.node_x;
          node_y_mem[fill_cnt]    = rq.node_y;
          node_cost_mem[fill_cnt] = rq.node_cost;
          node_par_mem[fill_cnt]  = rq.parent_index;
          node_has_par[fill_cnt]  = rq.parent_present;
          open_mark[fill_cnt]     = 1'b1;
          r.ok           = 1'b1;
          r.result_index = fill_cnt[RIDX_W-1:0];
          fill_cnt++;
        end
      end
      REQ_BEST: begin
        best_cost = COST_LIMIT;
        best      = 0;
        found     = 1'b0;
        for (int i = 0; i < fill_cnt; i++) begin
          if (open_mark[i] && node_cost_mem[i] < best_cost) begin
            best_cost = node_cost_mem[i];
            best      = i;
            found     = 1'b1;
          end
        end
        if (found) begin
          r.ok           = 1'b1;
          r.result_index = best[RIDX_W-1:0];
          r.out_x        = node_x_mem[best];
          r.out_y        = node_y_mem[best];
          r.out_cost     = node_cost_mem[best];
        end
      end
      REQ_CLOSE: begin
        if (rq.target_index < POOL_DEPTH) begin
          open_mark[rq.target_index[IDX_W-1:0]] = 1'b0;
          r.ok = 1'b1;
        end
      end
      REQ_COUNT_CLOSED, REQ_COUNT_OPEN: begin
        n = 0;
        for (int i = 0; i < fill_cnt; i++)
          if (open_mark[i] == (rq.req_type == REQ_COUNT_OPEN)) n++;
        r.count = n[COUNT_W-1:0];
      end
      REQ_LOOKUP: begin
        for (int i = 0; i < fill_cnt; i++)
          if (node_x_mem[i] == rq.node_x && node_y_mem[i] == rq.node_y) r.ok = 1'b1;
      end
      default: begin
        if (rq.target_index < fill_cnt) begin
          r.ok             = 1'b1;
          r.out_x          = node_x_mem[rq.target_index[IDX_W-1:0]];
          r.out_y          = node_y_mem[rq.target_index[IDX_W-1:0]];
          r.out_cost       = node_cost_mem[rq.target_index[IDX_W-1:0]];
          r.out_parent     = node_par_mem[rq.target_index[IDX_W-1:0]];
          r.out_has_parent = node_has_par[rq.target_index[IDX_W-1:0]];
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_beat_t mk(req_type_t t, int x, int y, int cost, int pidx, int pp,
                                  int tgt);
    in_beat_t b;
    b.req_type       = t;
    b.node_x         = x[COORD_W-1:0];
    b.node_y         = y[COORD_W-1:0];
    b.node_cost      = cost[COST_W-1:0];
    b.parent_index   = pidx[PIDX_W-1:0];
    b.parent_present = pp[0];
    b.target_index   = tgt[TGT_W-1:0];
    return b;
  endfunction

  function automatic in_beat_t rand_beat();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return in_beat_t'(raw[$bits(in_beat_t)-1:0]);
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 3))
      0: return COST_W'($urandom_range(0, 15));
      1: return COST_W'($urandom_range(99995, 100004));
      2: return COST_W'($urandom_range(0, 20'hFFFFF));
      default: return COST_W'($urandom_range(0, 99999));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 1)) return COORD_W'($urandom_range(0, 7));
    return COORD_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic queue_req(in_beat_t b, bit wait_idle);
    req_item_t it;
    it.beat      = b;
    it.wait_idle = wait_idle;
    req_queue = {req_queue, it};
    if (b.req_type == REQ_CLEAR) begin
      gen_fill = 0;
    end else if (b.req_type == REQ_APPEND && gen_fill < POOL_DEPTH) begin
      gen_x[gen_fill] = b.node_x;
      gen_y[gen_fill] = b.node_y;
      gen_fill++;
    end
  endtask

  task automatic add_random_op();
    in_beat_t b;
    int       sel;
    int       k;
    b   = rand_beat();
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      b.req_type  = REQ_APPEND;
      b.node_x    = pick_coord();
      b.node_y    = pick_coord();
      b.node_cost = pick_cost();
    end else if (sel < 45) begin
      b.req_type = REQ_BEST;
    end else if (sel < 60) begin
      b.req_type = REQ_CLOSE;
      if ($urandom_range(0, 4) != 0) b.target_index = TGT_W'($urandom_range(0, gen_fill));
    end else if (sel < 70) begin
      b.req_type = $urandom_range(0, 1) ? REQ_COUNT_OPEN : REQ_COUNT_CLOSED;
    end else if (sel < 82) begin
      b.req_type = REQ_LOOKUP;
      if (gen_fill > 0 && $urandom_range(0, 1)) begin
        k        = $urandom_range(0, gen_fill - 1);
        b.node_x = gen_x[k];
        b.node_y = gen_y[k];
      end else begin
        b.node_x = pick_coord();
        b.node_y = pick_coord();
      end
    end else if (sel < 95) begin
      b.req_type = REQ_READ;
      if ($urandom_range(0, 3) != 0) b.target_index = TGT_W'($urandom_range(0, gen_fill));
    end
    // the rest go out as raw noise
    queue_req(b, 1'b0);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // driver: offers queued requests, predicts each one as it is accepted
  always @(posedge clk) begin : drive_proc
    req_item_t nxt;
    out_beat_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        res = pool_predict(in_data);
        pending_results = {pending_results, res};
        n_in++;
      end
      if (in_valid && !in_ready) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (req_queue[0].wait_idle && pending_results.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        nxt = req_queue.pop_front();
        in_data  <= nxt.beat;
        in_valid <= 1'b1;
        if (req_queue.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 6);
      end
    end
  end

  // monitor: takes result beats and compares them with the oldest prediction
  always @(posedge clk) begin : mon_proc
    out_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding");
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_data.ok));
          check_field("result_index", 32'(want.result_index), 32'(out_data.result_index));
          check_field("out_x", 32'(want.out_x), 32'(out_data.out_x));
          check_field("out_y", 32'(want.out_y), 32'(out_data.out_y));
          check_field("out_cost", 32'(want.out_cost), 32'(out_data.out_cost));
          check_field("out_parent", 32'(want.out_parent), 32'(out_data.out_parent));
          check_field("out_has_parent", 32'(want.out_has_parent),
                      32'(out_data.out_has_parent));
          check_field("count", 32'(want.count), 32'(out_data.count));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_in >= HOLD_AT) begin
        // long back-pressure so the block fills and stalls its input
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (req_queue.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int  ep;
    int  n_rand;
    int  total;
    bit  full_done;
    // empty pool queries
    queue_req(mk(REQ_BEST, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_COUNT_OPEN, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_LOOKUP, 0, 0, 0, 0, 0, 0), 1'b0);
    // field extremes and costs around the eligibility limit
    queue_req(mk(REQ_APPEND, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_APPEND, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 511, 1, 1023), 1'b0);
    queue_req(mk(REQ_APPEND, 1, 2, 99999, 0, 1, 0), 1'b0);
    queue_req(mk(REQ_APPEND, 3, 4, 100000, 7, 0, 0), 1'b0);
    queue_req(mk(REQ_APPEND, 5, 5, 0, 2, 1, 0), 1'b0);
    // tie on cost goes to the lower index, then closes walk the winner along
    queue_req(mk(REQ_BEST, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_CLOSE, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_BEST, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_CLOSE, 0, 0, 0, 0, 0, 4), 1'b0);
    queue_req(mk(REQ_BEST, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_CLOSE, 0, 0, 0, 0, 0, 2), 1'b0);
    queue_req(mk(REQ_BEST, 0, 0, 0, 0, 0, 0), 1'b0);
    // close out of range and close of a slot not yet appended
    queue_req(mk(REQ_CLOSE, 0, 0, 0, 0, 0, 512), 1'b0);
    queue_req(mk(REQ_CLOSE, 0, 0, 0, 0, 0, 1023), 1'b0);
    queue_req(mk(REQ_CLOSE, 0, 0, 0, 0, 0, 511), 1'b0);
    queue_req(mk(REQ_COUNT_CLOSED, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_COUNT_OPEN, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_LOOKUP, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_LOOKUP, 1, 3, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_READ, 0, 0, 0, 0, 0, 1), 1'b0);
    queue_req(mk(REQ_READ, 0, 0, 0, 0, 0, 5), 1'b0);
    queue_req(mk(REQ_READ, 0, 0, 0, 0, 0, 1023), 1'b0);
    queue_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0), 1'b0);

    ep        = 0;
    n_rand    = 0;
    full_done = 1'b0;
    while (n_rand < SMALL_TARGET) begin
      if (!full_done && n_rand >= FULL_AT) begin
        // one pass to capacity, with a close of the last slot before it is appended
        full_done = 1'b1;
        queue_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 1'b1);
        for (int i = 0; i < POOL_DEPTH; i++) begin
          queue_req(mk(REQ_APPEND, int'(pick_coord()), int'(pick_coord()),
                       int'(pick_cost()), int'($urandom_range(0, 511)),
                       int'($urandom_range(0, 1)), 0), 1'b0);
          if (i == 100) queue_req(mk(REQ_CLOSE, 0, 0, 0, 0, 0, POOL_DEPTH - 1), 1'b0);
        end
        queue_req(mk(REQ_APPEND, 9, 9, 1, 0, 0, 0), 1'b0);
        queue_req(mk(REQ_BEST, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_req(mk(REQ_COUNT_OPEN, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_req(mk(REQ_COUNT_CLOSED, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_req(mk(REQ_LOOKUP, int'(gen_x[POOL_DEPTH-1]), int'(gen_y[POOL_DEPTH-1]),
                     0, 0, 0, 0), 1'b0);
        queue_req(mk(REQ_READ, 0, 0, 0, 0, 0, POOL_DEPTH - 1), 1'b0);
        queue_req(mk(REQ_READ, 0, 0, 0, 0, 0, POOL_DEPTH), 1'b0);
        for (int i = 0; i < 16; i++) add_random_op();
      end
      queue_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), ep % 6 == 0);
      n_rand++;
      for (int i = $urandom_range(8, 40); i > 0; i--) begin
        add_random_op();
        n_rand++;
      end
      ep++;
    end
    total = req_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (n_in < total || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests over %0d episodes, %0d result beats compared", n_in, ep, n_out);
    $display("covered empty and full pool, overflow, cost limit ties and long output stall");
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/aonl_pkg.sv
rtl/core/aonl_ram.sv
rtl/core/aonl_ctrl.sv
rtl/core/aonl_dp.sv
rtl/core/astar_open_list_node_table_core.sv
rtl/core/aonl_checker.sv
sim/astar_open_list_node_table_core_tb.sv
